[sv/ptg_pkg.sv]
// shared constants, types and the quarter-wave sine table of the tone generator
`timescale 1ns / 1ps
`default_nettype none

package ptg_pkg;

  localparam int PHASE_BITS     = 32;
  localparam int TAB_ADDR_BITS  = 10;
  localparam int SAMPLE_BITS    = 16;
  localparam int MAX_BLOCK      = 4096;

  localparam int TAB_N          = 1 << TAB_ADDR_BITS;
  localparam int MAG_BITS       = SAMPLE_BITS - 1;
  localparam int BCNT_BITS      = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int STEP_BITS      = 32;
  localparam int START_BITS     = 32;
  localparam int BLEN_BITS      = 13;
  localparam int PADDR_BITS     = 4;
  localparam int PDATA_BITS     = 32;

  localparam logic [MAG_BITS-1:0] AMPL = {MAG_BITS{1'b1}};
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

  typedef enum logic [1:0] {
    REG_PHASE_STEP   = 2'd0,
    REG_START_PHASE  = 2'd1,
    REG_TONE_KIND    = 2'd2,
    REG_BLOCK_LENGTH = 2'd3
  } reg_addr_e;

  typedef struct packed {
    logic signed [STEP_BITS-1:0] phase_step;
    logic [START_BITS-1:0]       start_phase;
    logic                        tone_kind;
    logic [BLEN_BITS-1:0]        block_length;
  } cfg_t;

  // per-sample decode carried alongside the table read
  typedef struct packed {
    logic sin_full;
    logic sin_neg;
    logic cos_full;
    logic cos_neg;
    logic cos_zero;
    logic last;
  } s1_t;

  typedef logic [MAG_BITS-1:0] qtab_t [TAB_N];

  function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // unsigned quotient by shift, compare and subtract
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // sine in Q62 for an angle in [0, pi/2), Taylor series
  function automatic logic [63:0] sin_q62(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n < 40; n++) begin
      if (term != 64'd0) begin
        term = div_u64(mul_q62(term, x2), 64'(2 * n) * 64'(2 * n + 1));
        if ((n % 2) == 1) sum = sum - term;
        else sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t        tab;
    logic [63:0]  coarse;
    logic [63:0]  fine;
    logic [63:0]  x;
    logic [63:0]  s;
    logic [127:0] p;
    coarse = HALF_PI_Q62 >> TAB_ADDR_BITS;
    fine   = HALF_PI_Q62 & 64'(TAB_N - 1);
    for (int k = 0; k < TAB_N; k++) begin
      x = coarse * 64'(k) + ((fine * 64'(k)) >> TAB_ADDR_BITS);
      s = sin_q62(x);
      p = {64'd0, 64'(AMPL)} * {64'd0, s} + (128'd1 << 61);
      tab[k] = p[62 +: MAG_BITS];
    end
    return tab;
  endfunction

  localparam qtab_t QUARTER_TAB = build_qtab();

endpackage

`default_nettype wire

[sv/ptg_in_if.sv]
// request channel: one transfer asks for one tone sample
`timescale 1ns / 1ps
`default_nettype none

interface ptg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

[sv/ptg_out_if.sv]
// sample channel: one transfer carries one cosine/sine sample pair
`timescale 1ns / 1ps
`default_nettype none

interface ptg_out_if import ptg_pkg::*; ;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] cos_out;
  logic signed [SAMPLE_BITS-1:0] sin_out;
  logic                          block_last;

  modport source (output valid, output cos_out, output sin_out, output block_last,
                  input ready);
  modport sink   (input valid, input cos_out, input sin_out, input block_last,
                  output ready);
endinterface

`default_nettype wire

[sv/ptg_ram.sv]
// generic ram, one write port, two registered read ports with shared enable
`timescale 1ns / 1ps
`default_nettype none

module ptg_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_a_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic      [Width-1:0]         rdata_a_o,
  output logic      [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

[sv/ptg_regs.sv]
// apb configuration registers of the tone generator
`timescale 1ns / 1ps
`default_nettype none

module ptg_regs import ptg_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_BITS-1:0] paddr,
  input  wire logic [PDATA_BITS-1:0] pwdata,
  output logic      [PDATA_BITS-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg_o
);

  cfg_t      cfg_q, cfg_d;
  reg_addr_e sel;
  logic      wr_en;

  assign sel    = reg_addr_e'(paddr[PADDR_BITS-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        REG_PHASE_STEP:   cfg_d.phase_step   = signed'(pwdata[STEP_BITS-1:0]);
        REG_START_PHASE:  cfg_d.start_phase  = pwdata[START_BITS-1:0];
        REG_TONE_KIND:    cfg_d.tone_kind    = pwdata[0];
        REG_BLOCK_LENGTH: cfg_d.block_length = pwdata[BLEN_BITS-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_PHASE_STEP:   prdata = PDATA_BITS'(unsigned'(cfg_q.phase_step));
      REG_START_PHASE:  prdata = PDATA_BITS'(cfg_q.start_phase);
      REG_TONE_KIND:    prdata = PDATA_BITS'(cfg_q.tone_kind);
      REG_BLOCK_LENGTH: prdata = PDATA_BITS'(cfg_q.block_length);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_step   <= '0;
      cfg_q.start_phase  <= '0;
      cfg_q.tone_kind    <= 1'b0;
      cfg_q.block_length <= BLEN_BITS'(1024);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

[sv/phase_accumulator_tone_generator.sv]
// top level of the phase-accumulator tone generator (nco)
`timescale 1ns / 1ps
`default_nettype none

// usage
// - in_i: one transfer per wanted sample; restart=1 reloads the phase from
//   start_phase and clears the block counter before that sample is made
// - out_o: cos_out / sin_out in q1.15 plus block_last on the last sample of a
//   block; cos_out is held at zero in real (sine-only) mode
// - apb port: phase_step at 0x0, start_phase at 0x4, tone_kind at 0x8,
//   block_length at 0xc; write only while no sample is in flight
// - pipeline: a request passes the table read stage, then the output register,
//   before its sample is valid
// - throughput: one sample per cycle while out_o.ready is high; the phase adder
//   and block counter update on each taken request and the table has two read ports
// - reset: after rst_ni rises the table ram is filled from the package
//   constant, one entry a cycle, all 1024 entries; in_i.ready stays low until done
// - stall: when out_o.ready is low the output register holds, the table stage
//   holds its read data, and in_i.ready drops once both are occupied
module phase_accumulator_tone_generator import ptg_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  ptg_in_if.sink                     in_i,
  ptg_out_if.source                  out_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_BITS-1:0] paddr,
  input  wire logic [PDATA_BITS-1:0] pwdata,
  output logic      [PDATA_BITS-1:0] prdata,
  output logic                       pready
);

  cfg_t cfg;

  ptg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // table fill after reset
  logic                     fill_busy_q, fill_busy_d;
  logic [TAB_ADDR_BITS-1:0] fill_addr_q, fill_addr_d;

  always_comb begin
    fill_busy_d = fill_busy_q;
    fill_addr_d = fill_addr_q;
    if (fill_busy_q) begin
      fill_addr_d = fill_addr_q + 1'b1;
      if (fill_addr_q == TAB_ADDR_BITS'(TAB_N - 1)) begin
        fill_busy_d = 1'b0;
      end
    end
  end

  // handshake and pipeline control
  logic out_valid_q, out_valid_d;
  logic s1_valid_q, s1_valid_d;
  logic out_free;
  logic s1_adv;
  logic in_fire;

  assign out_free    = ~out_valid_q | out_o.ready;
  assign s1_adv      = s1_valid_q & out_free;
  assign in_i.ready  = ~fill_busy_q & (~s1_valid_q | s1_adv);
  assign in_fire     = in_i.valid & in_i.ready;
  assign s1_valid_d  = in_fire | (s1_valid_q & ~s1_adv);
  assign out_valid_d = s1_adv | (out_valid_q & ~out_o.ready);

  // phase accumulator and block counter
  logic [PHASE_BITS-1:0] phase_acc_q, phase_acc_d;
  logic [BCNT_BITS-1:0]  block_count_q, block_count_d;
  logic [PHASE_BITS-1:0] phase_cur;
  logic [BCNT_BITS-1:0]  count_cur;
  logic [BCNT_BITS-1:0]  len_m1;
  logic                  is_last;

  always_comb begin
    if (cfg.block_length == '0) begin
      len_m1 = '0;
    end else if (cfg.block_length > BLEN_BITS'(MAX_BLOCK)) begin
      len_m1 = BCNT_BITS'(MAX_BLOCK - 1);
    end else begin
      len_m1 = BCNT_BITS'(cfg.block_length - 1'b1);
    end
  end

  assign phase_cur = in_i.restart ? PHASE_BITS'(cfg.start_phase) : phase_acc_q;
  assign count_cur = in_i.restart ? '0 : block_count_q;
  assign is_last   = (count_cur >= len_m1);

  always_comb begin
    phase_acc_d   = phase_acc_q;
    block_count_d = block_count_q;
    if (in_fire) begin
      phase_acc_d   = phase_cur + PHASE_BITS'(cfg.phase_step);
      block_count_d = is_last ? '0 : count_cur + 1'b1;
    end
  end

  // quadrant decode; cosine is the sine one quadrant ahead
  logic [1:0]               quad;
  logic [1:0]               quad_c;
  logic [TAB_ADDR_BITS-1:0] tab_addr;
  logic [TAB_ADDR_BITS-1:0] sin_addr;
  logic [TAB_ADDR_BITS-1:0] cos_addr;
  logic                     addr_zero;
  s1_t                      s1_q, s1_d;

  assign quad      = phase_cur[PHASE_BITS-1 -: 2];
  assign quad_c    = quad + 2'd1;
  assign tab_addr  = phase_cur[PHASE_BITS-3 -: TAB_ADDR_BITS];
  assign addr_zero = (tab_addr == '0);
  // odd quadrants read the table mirrored
  assign sin_addr  = quad[0]   ? TAB_ADDR_BITS'(0) - tab_addr : tab_addr;
  assign cos_addr  = quad_c[0] ? TAB_ADDR_BITS'(0) - tab_addr : tab_addr;

  always_comb begin
    s1_d          = s1_q;
    if (in_fire) begin
      s1_d.sin_full = quad[0] & addr_zero;
      s1_d.sin_neg  = quad[1];
      s1_d.cos_full = quad_c[0] & addr_zero;
      s1_d.cos_neg  = quad_c[1];
      s1_d.cos_zero = cfg.tone_kind;
      s1_d.last     = is_last;
    end
  end

  logic [MAG_BITS-1:0] sin_mag_raw;
  logic [MAG_BITS-1:0] cos_mag_raw;

  ptg_ram #(
    .Width (MAG_BITS),
    .Depth (TAB_N)
  ) u_qtab (
    .clk_i     (clk_i),
    .we_i      (fill_busy_q),
    .waddr_i   (fill_addr_q),
    .wdata_i   (QUARTER_TAB[fill_addr_q]),
    .re_i      (in_fire),
    .raddr_a_i (sin_addr),
    .raddr_b_i (cos_addr),
    .rdata_a_o (sin_mag_raw),
    .rdata_b_o (cos_mag_raw)
  );

  // output stage: full scale at the quadrant edge, sign per quadrant
  logic [SAMPLE_BITS-1:0] sin_mag, cos_mag;
  logic [SAMPLE_BITS-1:0] sin_val, cos_val;
  logic [SAMPLE_BITS-1:0] sin_out_q, sin_out_d;
  logic [SAMPLE_BITS-1:0] cos_out_q, cos_out_d;
  logic                   last_q, last_d;

  assign sin_mag = {1'b0, (s1_q.sin_full ? AMPL : sin_mag_raw)};
  assign cos_mag = {1'b0, (s1_q.cos_full ? AMPL : cos_mag_raw)};
  assign sin_val = s1_q.sin_neg ? SAMPLE_BITS'(0) - sin_mag : sin_mag;
  assign cos_val = s1_q.cos_neg ? SAMPLE_BITS'(0) - cos_mag : cos_mag;

  always_comb begin
    sin_out_d = sin_out_q;
    cos_out_d = cos_out_q;
    last_d    = last_q;
    if (s1_adv) begin
      sin_out_d = sin_val;
      cos_out_d = s1_q.cos_zero ? '0 : cos_val;
      last_d    = s1_q.last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.sin_out    = signed'(sin_out_q);
  assign out_o.cos_out    = signed'(cos_out_q);
  assign out_o.block_last = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_busy_q   <= 1'b1;
      fill_addr_q   <= '0;
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      phase_acc_q   <= '0;
      block_count_q <= '0;
    end else begin
      fill_busy_q   <= fill_busy_d;
      fill_addr_q   <= fill_addr_d;
      s1_valid_q    <= s1_valid_d;
      out_valid_q   <= out_valid_d;
      phase_acc_q   <= phase_acc_d;
      block_count_q <= block_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q      <= s1_d;
    sin_out_q <= sin_out_d;
    cos_out_q <= cos_out_d;
    last_q    <= last_d;
  end

  // no request is taken while the table is still being filled
  a_no_accept_in_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_busy_q |-> !in_i.ready)
    else $error("request taken during table fill");

  // an accepted request always reaches the table stage next cycle
  a_accept_to_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted request lost before table stage");

  // a stalled table stage keeps its decode so the held read data stays paired
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_q)))
    else $error("table stage changed while stalled");

  // the table scale never produces the most negative code
  a_no_min_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (sin_out_q != {1'b1, {MAG_BITS{1'b0}}}) &&
                    (cos_out_q != {1'b1, {MAG_BITS{1'b0}}}))
    else $error("sample outside symmetric range");

endmodule

`default_nettype wire
